@@ hdl/rprt_pkg.sv @@
// types and codes shared by the reserved port range table
`default_nettype none

package rprt_pkg;

	typedef enum logic [1:0] {
		OP_ADD   = 2'd0,
		OP_DEL   = 2'd1,
		OP_CHECK = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	localparam logic [2:0] STAT_OK        = 3'd0;
	localparam logic [2:0] STAT_NOT_FOUND = 3'd1;
	localparam logic [2:0] STAT_FULL      = 3'd2;
	localparam logic [2:0] STAT_DENIED    = 3'd3;
	localparam logic [2:0] STAT_INVALID   = 3'd4;

	typedef struct packed {
		logic        deleted;
		logic [15:0] hi;
		logic [15:0] lo;
	} entry_t;

	typedef struct packed {
		logic        exact;
		logic [15:0] lo;
		logic [15:0] hi;
		logic [15:0] port;
	} key_t;

endpackage

`default_nettype wire

@@ hdl/rprt_table.sv @@
// range table memory with registered read and the shared entry compare unit
`default_nettype none

module rprt_table #(
	parameter int TABLE_DEPTH = 64,
	parameter int IDX_W = 6
) (
	input  wire logic                 clk,
	input  wire logic                 rd_en,
	input  wire logic [IDX_W-1:0]     rd_addr,
	input  wire logic                 wr_en,
	input  wire logic [IDX_W-1:0]     wr_addr,
	input  wire rprt_pkg::entry_t     wr_data,
	input  wire rprt_pkg::key_t       key,
	output logic                      hit
);

	rprt_pkg::entry_t mem [TABLE_DEPTH];
	rprt_pkg::entry_t rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	// exact bounds match for add/delete, live cover for check
	always_comb begin
		if (key.exact) begin
			hit = (rd_q.lo == key.lo) && (rd_q.hi == key.hi);
		end else begin
			hit = !rd_q.deleted && (rd_q.lo <= key.port) && (key.port <= rd_q.hi);
		end
	end

endmodule

`default_nettype wire

@@ hdl/reserved_port_range_table_top.sv @@
// reserved port range table: sequencer, entry count and result register
//
// channel   direction  handshake                 payload
// config    in         restrict_we               restrict_enable
// item      in         start & !busy             operation, range_low, range_high, port
// result    out        done (one cycle)          status
//
// an add, delete or enabled check scans the table one entry a cycle through the
// single memory read port; done rises as busy falls at the end of the scan
// other items give their result in the cycle after acceptance and leave busy low
// a scan stops early at the first matching entry
// reset clears the entry count and the enable; table contents need no clearing
// results cannot be stalled; done pulses for one cycle
`default_nettype none

module reserved_port_range_table_top #(
	parameter int TABLE_DEPTH = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        restrict_we,
	input  wire logic        restrict_enable,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  operation,
	input  wire logic [15:0] range_low,
	input  wire logic [15:0] range_high,
	input  wire logic [15:0] port,
	output logic             done,
	output logic [2:0]       status
);

	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

	typedef enum logic {
		S_IDLE,
		S_SCAN
	} state_t;

	state_t            state_q;
	rprt_pkg::op_t     op_q;
	logic [15:0]       lo_q;
	logic [15:0]       hi_q;
	logic [15:0]       port_q;
	logic [CNT_W-1:0]  issue_q;
	logic [CNT_W-1:0]  used_q;
	logic              vld_s1;
	logic [IDX_W-1:0]  idx_s1;
	logic              restrict_q;
	logic              done_q;
	logic [2:0]        status_q;

	logic              rd_en;
	logic              wr_en;
	logic [IDX_W-1:0]  wr_addr;
	rprt_pkg::entry_t  wr_data;
	rprt_pkg::key_t    key;
	logic              hit;
	logic              hit_any;
	logic              scan_end;
	logic              room;
	logic [2:0]        scan_status;
	rprt_pkg::op_t     op_in;

	assign op_in = rprt_pkg::op_t'(operation);
	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign status = status_q;

	assign key.exact = (op_q != rprt_pkg::OP_CHECK);
	assign key.lo = lo_q;
	assign key.hi = hi_q;
	assign key.port = port_q;

	assign room = (used_q < DEPTH_C);
	assign hit_any = vld_s1 && hit;
	assign rd_en = (state_q == S_SCAN) && (issue_q < used_q);
	assign scan_end = (state_q == S_SCAN) && (hit_any || (!vld_s1 && (issue_q == used_q)));

	always_comb begin
		wr_en = scan_end && (op_q != rprt_pkg::OP_CHECK)
			&& (hit_any || ((op_q == rprt_pkg::OP_ADD) && room));
		wr_addr = hit_any ? idx_s1 : used_q[IDX_W-1:0];
		wr_data.deleted = (op_q == rprt_pkg::OP_DEL);
		wr_data.hi = hi_q;
		wr_data.lo = lo_q;
	end

	always_comb begin
		case (op_q)
			rprt_pkg::OP_CHECK: begin
				scan_status = hit_any ? rprt_pkg::STAT_DENIED : rprt_pkg::STAT_OK;
			end
			rprt_pkg::OP_DEL: begin
				scan_status = hit_any ? rprt_pkg::STAT_OK : rprt_pkg::STAT_NOT_FOUND;
			end
			rprt_pkg::OP_ADD: begin
				scan_status = (hit_any || room) ? rprt_pkg::STAT_OK : rprt_pkg::STAT_FULL;
			end
			default: begin
				scan_status = rprt_pkg::STAT_OK;
			end
		endcase
	end

	rprt_table #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.IDX_W(IDX_W)
	) u_table (
		.clk(clk),
		.rd_en(rd_en),
		.rd_addr(issue_q[IDX_W-1:0]),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.key(key),
		.hit(hit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			used_q <= '0;
			issue_q <= '0;
			vld_s1 <= 1'b0;
			restrict_q <= 1'b0;
			done_q <= 1'b0;
			status_q <= rprt_pkg::STAT_OK;
		end else begin
			done_q <= 1'b0;
			if (restrict_we) begin
				restrict_q <= restrict_enable;
			end
			case (state_q)
				S_IDLE: begin
					vld_s1 <= 1'b0;
					if (start) begin
						op_q <= op_in;
						lo_q <= range_low;
						hi_q <= range_high;
						port_q <= port;
						issue_q <= '0;
						if (op_in == rprt_pkg::OP_NONE) begin
							done_q <= 1'b1;
							status_q <= rprt_pkg::STAT_OK;
						end else if ((op_in != rprt_pkg::OP_CHECK)
								&& (range_low > range_high)) begin
							done_q <= 1'b1;
							status_q <= rprt_pkg::STAT_INVALID;
						end else if ((op_in == rprt_pkg::OP_CHECK) && !restrict_q) begin
							done_q <= 1'b1;
							status_q <= rprt_pkg::STAT_OK;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					vld_s1 <= rd_en;
					idx_s1 <= issue_q[IDX_W-1:0];
					if (rd_en) begin
						issue_q <= issue_q + 1'b1;
					end
					if (scan_end) begin
						state_q <= S_IDLE;
						vld_s1 <= 1'b0;
						done_q <= 1'b1;
						status_q <= scan_status;
						if ((op_q == rprt_pkg::OP_ADD) && !hit_any && room) begin
							used_q <= used_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= DEPTH_C)
		else $error("entry count above table depth");

	a_used_step: assert property (@(posedge clk) disable iff (!arst_n)
		(used_q == $past(used_q)) || (used_q == $past(used_q) + 1'b1))
		else $error("entry count moved by more than one");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (state_q == S_IDLE))
		else $error("result strobe while scanning");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && (status_q == rprt_pkg::STAT_FULL)) |-> (used_q == DEPTH_C))
		else $error("table full reported with room left");

	a_issue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (issue_q <= used_q))
		else $error("scan index past used entries");
`endif

endmodule

`default_nettype wire

@@ test/tb_top.sv @@
// self-checking testbench for the reserved port range table: directed table, then random items
`default_nettype none

module tb_top;

	localparam int DEPTH = 64;
	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASES = 5;
	localparam int PHASE_ITEMS = 106;
	localparam int PLAN_ROWS = 25;

	typedef struct packed {
		logic          cfg;
		logic          en;
		rprt_pkg::op_t op;
		logic [15:0]   lo;
		logic [15:0]   hi;
		logic [15:0]   p;
		logic          typed;
		logic [2:0]    st;
	} plan_row_t;

	logic        clk;
	logic        arst_n;
	logic        restrict_we;
	logic        restrict_enable;
	logic        start;
	logic        busy;
	logic [1:0]  operation;
	logic [15:0] range_low;
	logic [15:0] range_high;
	logic [15:0] port;
	logic        done;
	logic [2:0]  status;

	logic [15:0] tbl_lo [DEPTH];
	logic [15:0] tbl_hi [DEPTH];
	bit          tbl_del [DEPTH];
	int          tbl_count = 0;
	bit          restrict_on = 1'b0;

	logic [2:0]  status_expected [$];
	int          errors = 0;
	int          cycles = 0;

	plan_row_t plan [PLAN_ROWS] = '{
		'{1'b1, 1'b0, rprt_pkg::OP_NONE,  16'd0,    16'd0,    16'd0,    1'b0, rprt_pkg::STAT_OK},
		'{1'b0, 1'b0, rprt_pkg::OP_CHECK, 16'h1234, 16'h0000, 16'd0,    1'b1, rprt_pkg::STAT_OK},
		'{1'b0, 1'b0, rprt_pkg::OP_CHECK, 16'h0000, 16'hffff, 16'hffff, 1'b1, rprt_pkg::STAT_OK},
		'{1'b0, 1'b0, rprt_pkg::OP_ADD,   16'd0,    16'd0,    16'hffff, 1'b1, rprt_pkg::STAT_OK},
		'{1'b0, 1'b0, rprt_pkg::OP_ADD,   16'hffff, 16'hffff, 16'd0,    1'b1, rprt_pkg::STAT_OK},
		'{1'b0, 1'b0, rprt_pkg::OP_ADD,   16'd100,  16'd50,   16'd75,
			1'b1, rprt_pkg::STAT_INVALID},
		'{1'b0, 1'b0, rprt_pkg::OP_DEL,   16'hffff, 16'd0,    16'd0,
			1'b1, rprt_pkg::STAT_INVALID},
		'{1'b0, 1'b0, rprt_pkg::OP_DEL,   16'd7,    16'd9,    16'd8,
			1'b1, rprt_pkg::STAT_NOT_FOUND},
		'{1'b0, 1'b0, rprt_pkg::OP_ADD,   16'd1000, 16'd2000, 16'h5555, 1'b1, rprt_pkg::STAT_OK},
		'{1'b0, 1'b0, rprt_pkg::OP_ADD,   16'd1000, 16'd2000, 16'haaaa, 1'b1, rprt_pkg::STAT_OK},
		'{1'b0, 1'b0, rprt_pkg::OP_DEL,   16'd1000, 16'd2000, 16'd0,    1'b1, rprt_pkg::STAT_OK},
		'{1'b0, 1'b0, rprt_pkg::OP_DEL,   16'd1000, 16'd2000, 16'hffff, 1'b1, rprt_pkg::STAT_OK},
		'{1'b0, 1'b0, rprt_pkg::OP_NONE,  16'hffff, 16'd0,    16'hffff, 1'b1, rprt_pkg::STAT_OK},
		'{1'b0, 1'b0, rprt_pkg::OP_ADD,   16'd0,    16'hffff, 16'd0,    1'b1, rprt_pkg::STAT_OK},
		'{1'b1, 1'b1, rprt_pkg::OP_NONE,  16'd0,    16'd0,    16'd0,    1'b0, rprt_pkg::STAT_OK},
		'{1'b0, 1'b0, rprt_pkg::OP_CHECK, 16'hffff, 16'h0000, 16'd0,
			1'b1, rprt_pkg::STAT_DENIED},
		'{1'b0, 1'b0, rprt_pkg::OP_DEL,   16'd0,    16'hffff, 16'd1,    1'b1, rprt_pkg::STAT_OK},
		'{1'b0, 1'b0, rprt_pkg::OP_CHECK, 16'd5,    16'd3,    16'd0,    1'b0, rprt_pkg::STAT_OK},
		'{1'b0, 1'b0, rprt_pkg::OP_CHECK, 16'd0,    16'd0,    16'hffff, 1'b0, rprt_pkg::STAT_OK},
		'{1'b0, 1'b0, rprt_pkg::OP_CHECK, 16'hffff, 16'd0,    16'd1500, 1'b0, rprt_pkg::STAT_OK},
		'{1'b0, 1'b0, rprt_pkg::OP_ADD,   16'd1000, 16'd2000, 16'd1500, 1'b0, rprt_pkg::STAT_OK},
		'{1'b0, 1'b0, rprt_pkg::OP_CHECK, 16'd0,    16'd0,    16'd1000, 1'b0, rprt_pkg::STAT_OK},
		'{1'b0, 1'b0, rprt_pkg::OP_CHECK, 16'd0,    16'd0,    16'd999,  1'b0, rprt_pkg::STAT_OK},
		'{1'b0, 1'b0, rprt_pkg::OP_CHECK, 16'd0,    16'd0,    16'd2001, 1'b0, rprt_pkg::STAT_OK},
		'{1'b0, 1'b0, rprt_pkg::OP_CHECK, 16'd0,    16'd0,    16'd2000, 1'b0, rprt_pkg::STAT_OK}
	};

	reserved_port_range_table_top #(
		.TABLE_DEPTH(DEPTH)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.restrict_we(restrict_we),
		.restrict_enable(restrict_enable),
		.start(start),
		.busy(busy),
		.operation(operation),
		.range_low(range_low),
		.range_high(range_high),
		.port(port),
		.done(done),
		.status(status)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [2:0] table_status(input rprt_pkg::op_t op,
			input logic [15:0] lo, input logic [15:0] hi, input logic [15:0] p);
		case (op)
		rprt_pkg::OP_ADD, rprt_pkg::OP_DEL: begin
			if (lo > hi)
				return rprt_pkg::STAT_INVALID;
			for (int i = 0; i < tbl_count; i++) begin
				if (tbl_lo[i] == lo && tbl_hi[i] == hi) begin
					tbl_del[i] = (op == rprt_pkg::OP_DEL);
					return rprt_pkg::STAT_OK;
				end
			end
			if (op == rprt_pkg::OP_DEL)
				return rprt_pkg::STAT_NOT_FOUND;
			if (tbl_count >= DEPTH)
				return rprt_pkg::STAT_FULL;
			tbl_lo[tbl_count] = lo;
			tbl_hi[tbl_count] = hi;
			tbl_del[tbl_count] = 1'b0;
			tbl_count++;
			return rprt_pkg::STAT_OK;
		end
		rprt_pkg::OP_CHECK: begin
			if (!restrict_on)
				return rprt_pkg::STAT_OK;
			for (int i = 0; i < tbl_count; i++) begin
				if (!tbl_del[i] && tbl_lo[i] <= p && p <= tbl_hi[i])
					return rprt_pkg::STAT_DENIED;
			end
			return rprt_pkg::STAT_OK;
		end
		default: begin
			return rprt_pkg::STAT_OK;
		end
		endcase
	endfunction

	task automatic drive_item(input rprt_pkg::op_t op, input logic [15:0] lo,
			input logic [15:0] hi, input logic [15:0] p, input logic typed,
			input logic [2:0] typed_st);
		logic [2:0] st;
		start <= 1'b1;
		operation <= op;
		range_low <= lo;
		range_high <= hi;
		port <= p;
		do
			@(posedge clk);
		while (busy);
		st = table_status(op, lo, hi, p);
		if (typed)
			st = typed_st;
		status_expected.push_back(st);
	endtask

	task automatic quiesce();
		start <= 1'b0;
		while (status_expected.size() != 0 || busy)
			@(posedge clk);
	endtask

	task automatic write_restrict(input logic en);
		restrict_we <= 1'b1;
		restrict_enable <= en;
		@(posedge clk);
		restrict_we <= 1'b0;
		restrict_on = en;
	endtask

	task automatic sender_gap(input bit steady);
		if (!steady && $urandom_range(0, 99) < 12) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 70)) @(posedge clk);
		end
	endtask

	task automatic random_item(output rprt_pkg::op_t op, output logic [15:0] lo,
			output logic [15:0] hi, output logic [15:0] p);
		int pick;
		int idx;
		int span;
		lo = 16'($urandom);
		hi = 16'($urandom);
		p = 16'($urandom);
		idx = (tbl_count > 0) ? int'($urandom_range(0, tbl_count - 1)) : 0;
		pick = int'($urandom_range(0, 99));
		if (pick < 35)
			op = rprt_pkg::OP_ADD;
		else if (pick < 55)
			op = rprt_pkg::OP_DEL;
		else if (pick < 95)
			op = rprt_pkg::OP_CHECK;
		else
			op = rprt_pkg::OP_NONE;
		pick = int'($urandom_range(0, 99));
		if (op == rprt_pkg::OP_ADD || op == rprt_pkg::OP_DEL) begin
			if (tbl_count > 0 && pick < 50) begin
				lo = tbl_lo[idx];
				hi = tbl_hi[idx];
			end else if (pick < 88) begin
				case ($urandom_range(0, 9))
				0: span = int'($urandom_range(0, 65535));
				1, 2: span = int'($urandom_range(0, 4095));
				default: span = int'($urandom_range(0, 255));
				endcase
				span = int'(lo) + span;
				hi = (span > 65535) ? 16'hffff : span[15:0];
			end else begin
				// inverted bounds
				lo = 16'($urandom_range(1, 65535));
				hi = 16'($urandom_range(0, lo - 1));
			end
		end else if (op == rprt_pkg::OP_CHECK && tbl_count > 0) begin
			if (pick < 50)
				p = 16'($urandom_range(tbl_hi[idx], tbl_lo[idx]));
			else if (pick < 56)
				p = tbl_lo[idx] - 16'd1;
			else if (pick < 62)
				p = tbl_hi[idx] + 16'd1;
		end
	endtask

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_top NOT OK");
			$finish;
		end
	end

	always @(posedge clk) begin
		logic [2:0] want;
		if (arst_n && done) begin
			if (status_expected.size() == 0) begin
				errors++;
				$error("status: expected none, actual %0d", status);
			end else begin
				want = status_expected.pop_front();
				if (status !== want) begin
					errors++;
					$error("status: expected %0d, actual %0d", want, status);
				end
			end
		end
	end

	initial begin
		rprt_pkg::op_t op;
		logic [15:0]   lo;
		logic [15:0]   hi;
		logic [15:0]   p;
		arst_n <= 1'b0;
		restrict_we <= 1'b0;
		restrict_enable <= 1'b0;
		start <= 1'b0;
		operation <= rprt_pkg::OP_NONE;
		range_low <= 16'd0;
		range_high <= 16'd0;
		port <= 16'd0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < PLAN_ROWS; r++) begin
			if (plan[r].cfg) begin
				quiesce();
				write_restrict(plan[r].en);
			end else begin
				drive_item(plan[r].op, plan[r].lo, plan[r].hi, plan[r].p, plan[r].typed,
					plan[r].st);
			end
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			quiesce();
			if (ph == 1)
				write_restrict(1'b0);
			else if (ph == 0 || ph == PHASES - 1)
				write_restrict(1'b1);
			else
				write_restrict(1'($urandom_range(0, 1)));
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// one phase runs with no gaps at all
				sender_gap(ph == 2);
				random_item(op, lo, hi, p);
				drive_item(op, lo, hi, p, 1'b0, rprt_pkg::STAT_OK);
			end
		end

		quiesce();
		repeat (70) @(posedge clk);
		if (errors == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule

`default_nettype wire
